// File: hw/rtl/scalar_kalman_nis_nees_assert.svh
// Assertion macros for the scalar Kalman filter with NIS/NEES statistics.
`ifndef SCALAR_KALMAN_NIS_NEES_ASSERT_SVH
`define SCALAR_KALMAN_NIS_NEES_ASSERT_SVH
`ifndef SYNTHESIS
`define SKF_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("skf assertion failed");
`define SKF_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("skf assertion failed");
`else
`define SKF_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define SKF_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// File: hw/rtl/skf_pkg.sv
// Shared types and constants of the scalar Kalman filter.
`timescale 1ns / 1ps
package skf_pkg;

    localparam int DATA_W    = 32;
    localparam int TOTAL_W   = 48;
    localparam int CFG_W     = 31;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_PROCESS_NOISE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MEAS_NOISE    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_VAR      = 2'd2;

    localparam logic [CFG_W-1:0] RST_PROCESS_NOISE = 31'd104858;
    localparam logic [CFG_W-1:0] RST_MEAS_NOISE    = 31'd262144;
    localparam logic [CFG_W-1:0] RST_INIT_VAR      = 31'd1048576;

    typedef struct packed {
        logic signed [DATA_W-1:0] measurement;
        logic signed [DATA_W-1:0] true_state;
        logic                     new_run;
        logic                     clear_sums;
    } in_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] estimate;
        logic [DATA_W-1:0]        variance;
        logic [DATA_W-1:0]        nis_value;
        logic [DATA_W-1:0]        nees_value;
        logic [TOTAL_W-1:0]       nis_total;
        logic [TOTAL_W-1:0]       nees_total;
    } out_t;

    typedef enum logic [4:0] {
        OP_IDLE,
        OP_LOAD,
        OP_PRED,
        OP_SUM_S,
        OP_MUL_NU2,
        OP_DIV_NIS,
        OP_CAP_NIS,
        OP_DIV_K,
        OP_CAP_K,
        OP_MUL_KNU,
        OP_UPD_X,
        OP_MUL_P,
        OP_UPD_P,
        OP_MUL_E2,
        OP_DIV_NEES,
        OP_CAP_NEES,
        OP_FINISH
    } op_t;

    typedef struct packed {
        op_t op;
    } cmd_t;

    typedef struct packed {
        logic div_done;
    } sts_t;

endpackage

// File: hw/rtl/scalar_kalman_nis_nees.sv
// Top level of the scalar random-walk Kalman filter with NIS and NEES sums.
// The bit-serial divider, run three times per word, sets most of the step time; it
// finishes early when the quotient saturates (zero or small divisor). A new input word
// is accepted only after the previous word has been posted to the output register.
// A finished word waits in the output register while the next input word is taken.
// Synchronous active-low reset: estimate 0, variance and registers to defaults, sums 0.
`timescale 1ns / 1ps
module scalar_kalman_nis_nees #(
    parameter int FRAC_BITS = 20,
    parameter int SUM_WIDTH = 48
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  skf_pkg::in_t                  s_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output skf_pkg::out_t                 m_data,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [skf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                   cfg_data
);
    import skf_pkg::*;

    cmd_t cmd;
    sts_t sts;

    assign cfg_ready = 1'b1;

    skf_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    skf_dp #(
        .FRAC_BITS (FRAC_BITS),
        .SUM_WIDTH (SUM_WIDTH)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .sts       (sts),
        .s_data    (s_data),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

endmodule

// File: hw/rtl/skf_div.sv
// Bit-serial 64 by 32 divider with a 32-bit quotient that saturates.
`timescale 1ns / 1ps
module skf_div (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [63:0] num,
    input  logic [31:0] den,
    output logic        done,
    output logic [31:0] quo
);
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic        sat_reg, sat_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic [31:0] den_reg, den_next;
    logic [31:0] rem_reg, rem_next;
    logic [31:0] q_reg, q_next;
    logic [32:0] trial;
    logic        ge;

    assign trial = {rem_reg, q_reg[31]};
    assign ge    = trial >= {1'b0, den_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        sat_next  = sat_reg;
        cnt_next  = cnt_reg;
        den_next  = den_reg;
        rem_next  = rem_reg;
        q_next    = q_reg;
        if (start) begin
            den_next = den;
            rem_next = num[63:32];
            q_next   = num[31:0];
            cnt_next = '1;
            if ((den == '0) || (num[63:32] >= den)) begin
                sat_next  = 1'b1;
                done_next = 1'b1;
            end else begin
                sat_next  = 1'b0;
                busy_next = 1'b1;
            end
        end else if (busy_reg) begin
            rem_next = ge ? 32'(trial - {1'b0, den_reg}) : trial[31:0];
            q_next   = {q_reg[30:0], ge};
            cnt_next = cnt_reg - 5'd1;
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        sat_reg <= sat_next;
        cnt_reg <= cnt_next;
        den_reg <= den_next;
        rem_reg <= rem_next;
        q_reg   <= q_next;
    end

    assign done = done_reg;
    assign quo  = sat_reg ? '1 : q_reg;

endmodule

// File: hw/rtl/skf_dp.sv
// Datapath: filter state, configuration, shared multiplier and divider.
`timescale 1ns / 1ps
module skf_dp #(
    parameter int FRAC_BITS = 20,
    parameter int SUM_WIDTH = 48
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  skf_pkg::cmd_t                 cmd,
    output skf_pkg::sts_t                 sts,
    input  skf_pkg::in_t                  s_data,
    output skf_pkg::out_t                 m_data,
    input  logic                          cfg_valid,
    input  logic [skf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                   cfg_data
);
    import skf_pkg::*;

    localparam int          KW     = FRAC_BITS + 1;
    localparam int          SW1    = SUM_WIDTH + 1;
    localparam logic [31:0] ONE    = 32'(64'd1 << FRAC_BITS);
    localparam logic [KW-1:0] ONE_K = KW'(ONE);

    logic [CFG_W-1:0]         q_reg, r_reg, p0_reg;
    logic signed [31:0]       z_reg, xt_reg, est_reg, xn_reg;
    logic [31:0]              var_reg, pm_reg, s_reg, nu_abs_reg, nis_reg;
    logic [31:0]              pnew_reg, e_abs_reg, nees_reg;
    logic                     nu_neg_reg;
    logic [63:0]              prod_reg;
    logic [KW-1:0]            k_reg;
    logic [SUM_WIDTH-1:0]     nis_acc_reg, nees_acc_reg;
    out_t                     m_data_reg;

    logic [32:0]              pm_sum, s_sum, nu_full, nu_mag, e_full, e_mag;
    logic [31:0]              pm_sat, s_sat;
    logic [31:0]              mul_a, mul_b;
    logic [63:0]              mul_p;
    logic [63:0]              div_num;
    logic [31:0]              div_den, div_quo;
    logic                     div_start, div_done;
    logic [KW-1:0]            k_cap;
    logic [63:0]              rnd;
    logic [32:0]              mag;
    logic [34:0]              delta, xsum;
    logic signed [31:0]       xn_sat;
    logic [SW1-1:0]           nis_add, nees_add;
    logic [SUM_WIDTH-1:0]     nis_new, nees_new;

    assign pm_sum = {1'b0, var_reg} + {2'b0, q_reg};
    assign pm_sat = pm_sum[32] ? '1 : pm_sum[31:0];
    assign s_sum  = {1'b0, pm_reg} + {2'b0, r_reg};
    assign s_sat  = s_sum[32] ? '1 : s_sum[31:0];

    assign nu_full = {z_reg[31], z_reg} - {est_reg[31], est_reg};
    assign nu_mag  = nu_full[32] ? (~nu_full + 33'd1) : nu_full;
    assign e_full  = {xn_reg[31], xn_reg} - {xt_reg[31], xt_reg};
    assign e_mag   = e_full[32] ? (~e_full + 33'd1) : e_full;

    always_comb begin
        case (cmd.op)
            OP_MUL_KNU: begin
                mul_a = 32'(k_reg);
                mul_b = nu_abs_reg;
            end
            OP_MUL_P: begin
                mul_a = 32'(ONE_K - k_reg);
                mul_b = pm_reg;
            end
            OP_MUL_E2: begin
                mul_a = e_abs_reg;
                mul_b = e_abs_reg;
            end
            default: begin
                mul_a = nu_abs_reg;
                mul_b = nu_abs_reg;
            end
        endcase
    end
    assign mul_p = mul_a * mul_b;

    assign div_start = (cmd.op == OP_DIV_NIS) || (cmd.op == OP_DIV_K)
                       || (cmd.op == OP_DIV_NEES);
    assign div_num   = (cmd.op == OP_DIV_K) ? (64'(pm_reg) << FRAC_BITS) : prod_reg;
    assign div_den   = (cmd.op == OP_DIV_NEES) ? pnew_reg : s_reg;

    skf_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .done    (div_done),
        .quo     (div_quo)
    );

    assign sts.div_done = div_done;
    assign k_cap = (div_quo > ONE) ? ONE_K : div_quo[KW-1:0];

    assign rnd   = nu_neg_reg ? (prod_reg + 64'(ONE - 32'd1)) : prod_reg;
    assign mag   = 33'(rnd >> FRAC_BITS);
    assign delta = nu_neg_reg ? (~{2'b0, mag} + 35'd1) : {2'b0, mag};
    assign xsum  = {{3{est_reg[31]}}, est_reg} + delta;

    always_comb begin
        if (!xsum[34] && (xsum[33:31] != 3'b000)) begin
            xn_sat = 32'sh7FFF_FFFF;
        end else if (xsum[34] && (xsum[33:31] != 3'b111)) begin
            xn_sat = 32'sh8000_0000;
        end else begin
            xn_sat = xsum[31:0];
        end
    end

    assign nis_add  = {1'b0, nis_acc_reg} + SW1'(nis_reg);
    assign nees_add = {1'b0, nees_acc_reg} + SW1'(nees_reg);
    assign nis_new  = nis_add[SUM_WIDTH] ? '1 : nis_add[SUM_WIDTH-1:0];
    assign nees_new = nees_add[SUM_WIDTH] ? '1 : nees_add[SUM_WIDTH-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            q_reg        <= RST_PROCESS_NOISE;
            r_reg        <= RST_MEAS_NOISE;
            p0_reg       <= RST_INIT_VAR;
            est_reg      <= '0;
            var_reg      <= {1'b0, RST_INIT_VAR};
            nis_acc_reg  <= '0;
            nees_acc_reg <= '0;
        end else begin
            if (cfg_valid) begin
                case (cfg_index)
                    CFG_PROCESS_NOISE: q_reg  <= cfg_data[CFG_W-1:0];
                    CFG_MEAS_NOISE:    r_reg  <= cfg_data[CFG_W-1:0];
                    CFG_INIT_VAR:      p0_reg <= cfg_data[CFG_W-1:0];
                    default: ;
                endcase
            end
            if (cmd.op == OP_LOAD) begin
                if (s_data.new_run) begin
                    est_reg <= '0;
                    var_reg <= {1'b0, p0_reg};
                end
                if (s_data.clear_sums) begin
                    nis_acc_reg  <= '0;
                    nees_acc_reg <= '0;
                end
            end
            if (cmd.op == OP_FINISH) begin
                est_reg      <= xn_reg;
                var_reg      <= pnew_reg;
                nis_acc_reg  <= nis_new;
                nees_acc_reg <= nees_new;
            end
        end
    end

    always_ff @(posedge aclk) begin
        case (cmd.op)
            OP_LOAD: begin
                z_reg  <= s_data.measurement;
                xt_reg <= s_data.true_state;
            end
            OP_PRED: begin
                pm_reg     <= pm_sat;
                nu_abs_reg <= nu_mag[31:0];
                nu_neg_reg <= nu_full[32];
            end
            OP_SUM_S: s_reg <= s_sat;
            OP_MUL_NU2, OP_MUL_KNU, OP_MUL_P, OP_MUL_E2: prod_reg <= mul_p;
            OP_CAP_NIS: nis_reg <= div_quo;
            OP_CAP_K: k_reg <= k_cap;
            OP_UPD_X: xn_reg <= xn_sat;
            OP_UPD_P: begin
                pnew_reg  <= 32'(prod_reg >> FRAC_BITS);
                e_abs_reg <= e_mag[31:0];
            end
            OP_CAP_NEES: nees_reg <= div_quo;
            OP_FINISH: begin
                m_data_reg.estimate   <= xn_reg;
                m_data_reg.variance   <= pnew_reg;
                m_data_reg.nis_value  <= nis_reg;
                m_data_reg.nees_value <= nees_reg;
                m_data_reg.nis_total  <= TOTAL_W'(nis_new);
                m_data_reg.nees_total <= TOTAL_W'(nees_new);
            end
            default: ;
        endcase
    end

    assign m_data = m_data_reg;

endmodule

// File: hw/rtl/skf_ctrl.sv
// Controller: sequences the filter step and owns the handshakes.
`timescale 1ns / 1ps
`include "scalar_kalman_nis_nees_assert.svh"
module skf_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    output logic          m_valid,
    input  logic          m_ready,
    input  skf_pkg::sts_t sts,
    output skf_pkg::cmd_t cmd
);
    import skf_pkg::*;

    typedef enum logic [15:0] {
        ST_IDLE      = 16'h0001,
        ST_PRED      = 16'h0002,
        ST_SUM_S     = 16'h0004,
        ST_MUL_NU2   = 16'h0008,
        ST_DIV_NIS   = 16'h0010,
        ST_WAIT_NIS  = 16'h0020,
        ST_DIV_K     = 16'h0040,
        ST_WAIT_K    = 16'h0080,
        ST_MUL_KNU   = 16'h0100,
        ST_UPD_X     = 16'h0200,
        ST_MUL_P     = 16'h0400,
        ST_UPD_P     = 16'h0800,
        ST_MUL_E2    = 16'h1000,
        ST_DIV_NEES  = 16'h2000,
        ST_WAIT_NEES = 16'h4000,
        ST_FINISH    = 16'h8000
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   out_free;

    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next = state_reg;
        cmd.op     = OP_IDLE;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.op     = OP_LOAD;
                    state_next = ST_PRED;
                end
            end
            ST_PRED: begin
                cmd.op     = OP_PRED;
                state_next = ST_SUM_S;
            end
            ST_SUM_S: begin
                cmd.op     = OP_SUM_S;
                state_next = ST_MUL_NU2;
            end
            ST_MUL_NU2: begin
                cmd.op     = OP_MUL_NU2;
                state_next = ST_DIV_NIS;
            end
            ST_DIV_NIS: begin
                cmd.op     = OP_DIV_NIS;
                state_next = ST_WAIT_NIS;
            end
            ST_WAIT_NIS: begin
                if (sts.div_done) begin
                    cmd.op     = OP_CAP_NIS;
                    state_next = ST_DIV_K;
                end
            end
            ST_DIV_K: begin
                cmd.op     = OP_DIV_K;
                state_next = ST_WAIT_K;
            end
            ST_WAIT_K: begin
                if (sts.div_done) begin
                    cmd.op     = OP_CAP_K;
                    state_next = ST_MUL_KNU;
                end
            end
            ST_MUL_KNU: begin
                cmd.op     = OP_MUL_KNU;
                state_next = ST_UPD_X;
            end
            ST_UPD_X: begin
                cmd.op     = OP_UPD_X;
                state_next = ST_MUL_P;
            end
            ST_MUL_P: begin
                cmd.op     = OP_MUL_P;
                state_next = ST_UPD_P;
            end
            ST_UPD_P: begin
                cmd.op     = OP_UPD_P;
                state_next = ST_MUL_E2;
            end
            ST_MUL_E2: begin
                cmd.op     = OP_MUL_E2;
                state_next = ST_DIV_NEES;
            end
            ST_DIV_NEES: begin
                cmd.op     = OP_DIV_NEES;
                state_next = ST_WAIT_NEES;
            end
            ST_WAIT_NEES: begin
                if (sts.div_done) begin
                    cmd.op     = OP_CAP_NEES;
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    cmd.op     = OP_FINISH;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if ((state_reg == ST_FINISH) && out_free) begin
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;

    `SKF_ASSERT_IMP(a_done_in_wait, aclk, aresetn, sts.div_done, (state_reg == ST_WAIT_NIS) || (state_reg == ST_WAIT_K) || (state_reg == ST_WAIT_NEES))
    `SKF_ASSERT_NXT(a_finish_posts, aclk, aresetn, (state_reg == ST_FINISH) && !m_valid_reg, m_valid_reg && (state_reg == ST_IDLE))
    `SKF_ASSERT_NXT(a_accept_starts, aclk, aresetn, s_valid && s_ready, (state_reg == ST_PRED) && !sts.div_done)

endmodule
